@@ sv/veb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// veb_pkg
// request codes and register addresses for the veb layout search tree
// ----------------------------------------------------------------------------
package veb_pkg;
  localparam logic [2:0] REQ_SET     = 3'd0;
  localparam logic [2:0] REQ_LINK    = 3'd1;
  localparam logic [2:0] REQ_RECOMP  = 3'd2;
  localparam logic [2:0] REQ_INSERT  = 3'd3;
  localparam logic [2:0] REQ_FIND    = 3'd4;
  localparam logic [0:0] REG_HEIGHT  = 1'd0;
endpackage

@@ sv/veb_layout_search_tree_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// veb_layout_search_tree_top
// binary search tree held in van emde boas order in two block memories
// ----------------------------------------------------------------------------
// Each memory access maps a node number to its slot, then reads, waits and
// uses the word. Set and link do one access, recompute three (one for a node
// on the last level), find one per level and insert up to one per level, as
// insert stops at the first empty node. A node outside the tree or an unknown
// code goes straight to done without an access. After reset a clearing pass
// zeroes both memories while busy stays high. Results appear for one cycle on
// done and cannot be held off by the receiver.
module veb_layout_search_tree_top #(
  parameter int MAX_HEIGHT = 10,
  parameter int KEY_BITS   = 32,
  parameter int LEAF_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  req_type,
  input  logic [MAX_HEIGHT-1:0]       node_index,
  input  logic signed [KEY_BITS-1:0]  key,
  input  logic [LEAF_BITS-1:0]        leaf_handle,
  output logic                        done,
  output logic [MAX_HEIGHT-1:0]       result_node,
  output logic [MAX_HEIGHT-1:0]       layout_addr,
  output logic signed [KEY_BITS-1:0]  node_key,
  output logic [LEAF_BITS-1:0]        node_leaf
);
  localparam int NW = MAX_HEIGHT;
  localparam int HW = $clog2(MAX_HEIGHT + 2);
  localparam int DEPTH = (1 << MAX_HEIGHT) - 1;
  localparam logic [NW-1:0] LAST = NW'(DEPTH - 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MAP   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_WAIT  = 4'd4;
  localparam logic [3:0] S_USE   = 4'd5;
  localparam logic [3:0] S_REP   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [KEY_BITS-1:0]  kmem [DEPTH];
  logic [LEAF_BITS-1:0] lmem [DEPTH];
  logic [KEY_BITS-1:0]  krd;
  logic [LEAF_BITS-1:0] lrd;
  logic [NW-1:0]        raddr;
  logic                 kwe, lwe;
  logic [NW-1:0]        waddr;
  logic [KEY_BITS-1:0]  kwd;

  logic [3:0]           state;
  logic [3:0]           phase;  // what the current read is for
  logic [HW-1:0]        height;
  logic [NW-1:0]        clr;
  logic [2:0]           req;
  logic [NW:0]          node;
  logic [KEY_BITS-1:0]  kreg;
  logic [LEAF_BITS-1:0] lreg;
  logic [KEY_BITS-1:0]  lv;
  logic [NW:0]          mb;      // mapping working node
  logic [HW-1:0]        mh;
  logic [NW:0]          moff;
  logic [NW-1:0]        slot;
  logic [HW-1:0]        lvl;

  localparam logic [3:0] P_DESC = 4'd1;
  localparam logic [3:0] P_LEFT = 4'd2;
  localparam logic [3:0] P_RGT  = 4'd3;
  localparam logic [3:0] P_WR   = 4'd4;

  function automatic logic [HW-1:0] lg(input logic [NW:0] v);
    logic [HW-1:0] r;
    r = '0;
    for (int i = 0; i <= NW; i++) if (v[i]) r = HW'(i);
    return r;
  endfunction

  function automatic logic [HW-1:0] p2c(input logic [HW-1:0] v);
    logic [HW:0] p;
    p = 1;
    for (int i = 0; i < HW + 1; i++) if (p < {1'b0, v}) p = p << 1;
    return HW'(p);
  endfunction

  // one split step of the layout mapping
  logic [HW-1:0] d_, bot_, top_, sd_;
  logic [NW:0]   sub_, mask_t, mask_b, nb_, noff_;
  always_comb begin
    d_ = lg(mb);
    bot_ = p2c(HW'((mh + 1'b1) >> 1));
    top_ = mh - bot_;
    sd_ = d_ - top_;
    sub_ = mb >> sd_;
    mask_t = (NW+1)'((1 << top_) - 1);
    mask_b = (NW+1)'((1 << bot_) - 1);
    nb_ = (mb & (NW+1)'((1 << sd_) - 1)) | (NW+1)'(1 << sd_);
    noff_ = moff + mask_t + (NW+1)'((sub_ & mask_t) * mask_b);
  end

  logic signed [KEY_BITS-1:0] ks, ns, lvs;
  assign ks  = kreg;
  assign ns  = krd;
  assign lvs = lv;

  logic [HW-1:0] ptr_level;
  assign ptr_level = lg(node);

  always_ff @(posedge clk) begin
    if (kwe) kmem[waddr] <= kwd;
    if (lwe) lmem[waddr] <= lreg;
    krd <= kmem[raddr];
    lrd <= lmem[raddr];
  end

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'd0) ? 32'(height) : 32'd0;
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr <= '0;
      height <= HW'(MAX_HEIGHT);
      done <= 1'b0;
      kwe <= 1'b0;
      lwe <= 1'b0;
    end else begin
      done <= 1'b0;
      kwe <= 1'b0;
      lwe <= 1'b0;
      if (psel && penable && pwrite && pready &&
          paddr[1:0] == 2'(veb_pkg::REG_HEIGHT)) begin
        if (pwdata[3:0] == 4'd0) height <= HW'(1);
        else if (32'(pwdata[3:0]) > MAX_HEIGHT) height <= HW'(MAX_HEIGHT);
        else height <= HW'(pwdata[3:0]);
      end
      unique case (state)
        S_CLR: begin
          kwe <= 1'b1; lwe <= 1'b1; waddr <= clr; kwd <= '0; lreg <= '0;
          clr <= clr + 1'b1;
          if (clr == LAST) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          req <= req_type; kreg <= key; lreg <= leaf_handle;
          if (req_type <= veb_pkg::REQ_RECOMP) begin
            if (node_index == '0 || lg({1'b0, node_index}) >= height) begin
              result_node <= node_index; layout_addr <= '0;
              node_key <= '0; node_leaf <= '0; state <= S_DONE;
            end else begin
              node <= {1'b0, node_index};
              phase <= (req_type == veb_pkg::REQ_RECOMP &&
                        lg({1'b0, node_index}) + 1'b1 < height) ? P_LEFT : P_WR;
              mb <= (req_type == veb_pkg::REQ_RECOMP &&
                     lg({1'b0, node_index}) + 1'b1 < height)
                    ? {node_index, 1'b0} : {1'b0, node_index};
              mh <= height; moff <= '0; state <= S_MAP;
            end
          end else if (req_type == veb_pkg::REQ_INSERT || req_type == veb_pkg::REQ_FIND) begin
            node <= (NW+1)'(1); lvl <= HW'(1);
            phase <= (height > HW'(1)) ? P_DESC : P_WR;
            mb <= (NW+1)'(1); mh <= height; moff <= '0;
            state <= S_MAP;
          end else begin
            result_node <= '0; layout_addr <= '0;
            node_key <= '0; node_leaf <= '0; state <= S_DONE;
          end
        end
        S_MAP: begin
          if (mh > HW'(2)) begin
            if (d_ < top_) mh <= top_;
            else begin mb <= nb_; moff <= noff_; mh <= bot_; end
          end else begin
            slot <= NW'(moff + mb - 1'b1);
            state <= S_RD;
          end
        end
        S_RD: begin raddr <= slot; state <= S_WAIT; end
        S_WAIT: state <= S_USE;
        S_USE: begin
          if (phase == P_LEFT) begin
            // walk right subtree down its left spine to the leaf level
            lv <= krd; phase <= P_RGT;
            mb  <= (({node[NW-1:0], 1'b1}) << (height - ptr_level - HW'(2)));
            mh <= height; moff <= '0; state <= S_MAP;
          end else if (phase == P_RGT) begin
            kreg <= ($signed(lvs) < $signed(ns)) ? krd : lv;
            phase <= P_WR; mb <= node; mh <= height; moff <= '0;
            state <= S_MAP;
          end else if (phase == P_DESC) begin
            if (req == veb_pkg::REQ_INSERT && krd == '0) begin
              phase <= P_WR; state <= S_USE;
            end else begin
              node <= (ks < ns) ? {node[NW-1:0], 1'b0} : {node[NW-1:0], 1'b1};
              mb <= (ks < ns) ? {node[NW-1:0], 1'b0} : {node[NW-1:0], 1'b1};
              mh <= height; moff <= '0; lvl <= lvl + 1'b1;
              phase <= (lvl + 1'b1 < height) ? P_DESC : P_WR;
              state <= S_MAP;
            end
          end else begin
            // final: slot holds node's slot, krd/lrd its contents
            result_node <= NW'(node); layout_addr <= slot;
            waddr <= slot; kwd <= kreg;
            if (req == veb_pkg::REQ_SET || req == veb_pkg::REQ_INSERT ||
                (req == veb_pkg::REQ_RECOMP && ptr_level + 1'b1 < height)) begin
              kwe <= 1'b1; node_key <= kreg;
            end else begin
              node_key <= krd;
            end
            if (req == veb_pkg::REQ_LINK) begin
              lwe <= 1'b1; node_leaf <= lreg;
            end else begin
              node_leaf <= lrd;
            end
            state <= S_REP;
          end
        end
        S_REP: state <= S_DONE;
        S_DONE: begin done <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
